// ===== sv/sma_crossover_detector_defines.svh =====
// Assertion macros for the crossover detector checker.
// No dependencies; included by the checker file by bare name.
`ifndef SMA_CROSSOVER_DETECTOR_DEFINES_SVH
`define SMA_CROSSOVER_DETECTOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SCD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SCD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/scd_pkg.sv =====
// Shared types and constants for the SMA crossover detector.
// No dependencies; used by every module of the block except scd_ring.
`timescale 1ns / 1ps

package scd_pkg;

  localparam int unsigned CFG_W       = 9;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned SIG_W       = 2;
  localparam int unsigned OUT_TDATA_W = 8;

  // Register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] REG_FAST_LEN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLOW_LEN = 2'd1;

  localparam logic [CFG_W-1:0] FAST_LEN_RST = 9'd5;
  localparam logic [CFG_W-1:0] SLOW_LEN_RST = 9'd20;

  typedef enum logic [1:0] {
    REL_EQUAL = 2'd0,
    REL_BELOW = 2'd1,
    REL_ABOVE = 2'd2
  } rel_e;

  typedef enum logic [SIG_W-1:0] {
    SIG_HOLD = 2'd0,
    SIG_BUY  = 2'd1,
    SIG_SELL = 2'd2
  } signal_e;

  // Accumulator stage control
  typedef struct packed {
    logic load;
    logic restart;
    logic sub_fast;
    logic sub_slow;
  } sum_ctl_t;

  // Multiply / compare stage control
  typedef struct packed {
    logic mul_en;
    logic out_en;
    logic full;
    logic restart;
  } rel_ctl_t;

endpackage

// ===== sv/scd_ring.sv =====
// Price history ring: one write port, two registered read ports.
// No package dependencies.
`timescale 1ns / 1ps

module scd_ring #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  // Read returns the old entry on a same-address write (full-window drop).
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// ===== sv/scd_sums.sv =====
// Running window sums: drop the oldest price, add the newest.
// Depends on scd_pkg (sum_ctl_t).
`timescale 1ns / 1ps

module scd_sums #(
  parameter int unsigned PRICE_BITS = 32,
  parameter int unsigned SUM_W      = 41
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  scd_pkg::sum_ctl_t   ctl_i,
  input  logic [PRICE_BITS-1:0] price_i,
  input  logic [PRICE_BITS-1:0] drop_fast_i,
  input  logic [PRICE_BITS-1:0] drop_slow_i,
  output logic [SUM_W-1:0]    fast_total_o,
  output logic [SUM_W-1:0]    slow_total_o
);

  logic [SUM_W-1:0] fast_total_q, fast_total_d;
  logic [SUM_W-1:0] slow_total_q, slow_total_d;

  always_comb begin
    fast_total_d = fast_total_q + SUM_W'(price_i)
                 - (ctl_i.sub_fast ? SUM_W'(drop_fast_i) : '0);
    slow_total_d = slow_total_q + SUM_W'(price_i)
                 - (ctl_i.sub_slow ? SUM_W'(drop_slow_i) : '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fast_total_q <= '0;
      slow_total_q <= '0;
    end else if (ctl_i.restart) begin
      fast_total_q <= '0;
      slow_total_q <= '0;
    end else if (ctl_i.load) begin
      fast_total_q <= fast_total_d;
      slow_total_q <= slow_total_d;
    end
  end

  assign fast_total_o = fast_total_q;
  assign slow_total_o = slow_total_q;

endmodule

// ===== sv/scd_relate.sv =====
// Cross-product compare of the two means and crossing decision.
// Depends on scd_pkg (rel_ctl_t, rel_e, signal_e).
`timescale 1ns / 1ps

module scd_relate #(
  parameter int unsigned SUM_W = 41,
  parameter int unsigned LEN_W = 9
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  scd_pkg::rel_ctl_t  ctl_i,
  input  logic [SUM_W-1:0]   fast_total_i,
  input  logic [SUM_W-1:0]   slow_total_i,
  input  logic [LEN_W-1:0]   fast_len_i,
  input  logic [LEN_W-1:0]   slow_len_i,
  output scd_pkg::signal_e   signal_o
);

  localparam int unsigned PROD_W = SUM_W + LEN_W;

  logic [PROD_W-1:0] prod_fast_q;
  logic [PROD_W-1:0] prod_slow_q;
  logic              full_q;
  scd_pkg::rel_e     prev_q;
  scd_pkg::rel_e     cur;
  scd_pkg::signal_e  signal_q, signal_d;

  // fast_total/fast_len vs slow_total/slow_len without division
  always_ff @(posedge clk_i) begin
    if (ctl_i.mul_en) begin
      prod_fast_q <= PROD_W'(fast_total_i) * PROD_W'(slow_len_i);
      prod_slow_q <= PROD_W'(slow_total_i) * PROD_W'(fast_len_i);
      full_q      <= ctl_i.full;
    end
  end

  always_comb begin
    if (prod_fast_q < prod_slow_q) begin
      cur = scd_pkg::REL_BELOW;
    end else if (prod_fast_q > prod_slow_q) begin
      cur = scd_pkg::REL_ABOVE;
    end else begin
      cur = scd_pkg::REL_EQUAL;
    end
    signal_d = scd_pkg::SIG_HOLD;
    if (full_q) begin
      if (prev_q == scd_pkg::REL_BELOW && cur == scd_pkg::REL_ABOVE) begin
        signal_d = scd_pkg::SIG_BUY;
      end else if (prev_q == scd_pkg::REL_ABOVE && cur == scd_pkg::REL_BELOW) begin
        signal_d = scd_pkg::SIG_SELL;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q   <= scd_pkg::REL_EQUAL;
      signal_q <= scd_pkg::SIG_HOLD;
    end else if (ctl_i.restart) begin
      prev_q <= scd_pkg::REL_EQUAL;
    end else if (ctl_i.out_en) begin
      signal_q <= signal_d;
      if (full_q) begin
        prev_q <= cur;
      end
    end
  end

  assign signal_o = signal_q;

endmodule

// ===== sv/sma_crossover_detector.sv =====
// Dual simple-moving-average crossover detector, top level.
// Depends on scd_pkg, scd_ring, scd_sums and scd_relate.
//
// Usage:
//  - s_axis carries one closing price per beat; m_axis returns one signal
//    per input beat, in order: 0 hold, 1 buy (fast mean crosses above slow),
//    2 sell (fast mean crosses below slow).
//  - cfg_we_i/cfg_idx_i/cfg_data_i write fast_len (index 0) and slow_len
//    (index 1). Any write to either register restarts the run: fill count,
//    both sums and the previous relation clear. Write only while idle.
//    Lengths of 0 act as 1, slow_len clamps to MAX_WINDOW, fast_len to slow.
//  - Each input beat passes through ring read, sum update, cross-product
//    multiply and compare into the output register, in that order.
//  - Throughput is one beat per cycle while m_axis is not stalled; the ring's
//    two read ports plus one write port per beat set that figure.
//  - Each stage advances when the stage after it is empty or moving, so
//    bubbles collapse; a stalled m_axis fills the stages, then drops
//    s_axis_tready. The output beat holds steady while stalled.
//  - Reset empties the pipeline, sets fast_len 5 and slow_len 20 and starts a
//    new run; the ring needs no clearing, the fill count guards unwritten slots.
`timescale 1ns / 1ps

module sma_crossover_detector #(
  parameter int unsigned MAX_WINDOW = 256,
  parameter int unsigned PRICE_BITS = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [scd_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [scd_pkg::CFG_W-1:0]           cfg_data_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [scd_pkg::IN_TDATA_W-1:0]      s_axis_tdata,   // [31:0] price
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [scd_pkg::OUT_TDATA_W-1:0]     m_axis_tdata    // [1:0] signal, [7:2] zero
);

  localparam int unsigned AW    = $clog2(MAX_WINDOW);
  localparam int unsigned LEN_W = $clog2(MAX_WINDOW + 1);
  localparam int unsigned SUM_W = PRICE_BITS + LEN_W;

  // ---------------- configuration ----------------
  logic [scd_pkg::CFG_W-1:0] fast_len_q;
  logic [scd_pkg::CFG_W-1:0] slow_len_q;
  logic                      restart;
  logic [LEN_W-1:0]          eff_slow;
  logic [LEN_W-1:0]          eff_fast;

  assign restart = cfg_we_i && (cfg_idx_i == scd_pkg::REG_FAST_LEN ||
                                cfg_idx_i == scd_pkg::REG_SLOW_LEN);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fast_len_q <= scd_pkg::FAST_LEN_RST;
      slow_len_q <= scd_pkg::SLOW_LEN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        scd_pkg::REG_FAST_LEN: fast_len_q <= cfg_data_i;
        scd_pkg::REG_SLOW_LEN: slow_len_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Effective lengths: zero acts as one, slow clamps to the ring, fast to slow
  always_comb begin
    if (slow_len_q == '0) begin
      eff_slow = LEN_W'(1);
    end else if (32'(slow_len_q) > MAX_WINDOW) begin
      eff_slow = LEN_W'(MAX_WINDOW);
    end else begin
      eff_slow = LEN_W'(slow_len_q);
    end
    if (fast_len_q == '0) begin
      eff_fast = LEN_W'(1);
    end else if (32'(fast_len_q) > 32'(eff_slow)) begin
      eff_fast = eff_slow;
    end else begin
      eff_fast = LEN_W'(fast_len_q);
    end
  end

  // ---------------- stage handshake ----------------
  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;
  logic acc, ld2, ld3, ld4;

  assign rdy4 = !v4_q || m_axis_tready;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  assign acc = s_axis_tvalid && rdy1;
  assign ld2 = v1_q && rdy2;
  assign ld3 = v2_q && rdy3;
  assign ld4 = v3_q && rdy4;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= acc || (v1_q && !ld2);
      v2_q <= ld2 || (v2_q && !ld3);
      v3_q <= ld3 || (v3_q && !ld4);
      v4_q <= ld4 || (v4_q && !(m_axis_tready));
    end
  end

  assign s_axis_tready = rdy1;
  assign m_axis_tvalid = v4_q;

  // ---------------- accept stage: pointer, fill count, ring reads ----------------
  logic [AW-1:0]         wp_q;
  logic [LEN_W-1:0]      fill_q, fill_d;
  logic [PRICE_BITS-1:0] price;
  logic [AW-1:0]         addr_fast, addr_slow;

  // Slot written k beats ago; k == MAX_WINDOW lands on the slot being written
  function automatic logic [AW-1:0] back_addr(logic [AW-1:0] wp, logic [LEN_W-1:0] k);
    logic [LEN_W:0] w;
    logic [LEN_W:0] kx;
    logic [LEN_W:0] d;
    w  = (LEN_W+1)'(wp);
    kx = (LEN_W+1)'(k);
    if (w >= kx) begin
      d = w - kx;
    end else begin
      d = w + (LEN_W+1)'(MAX_WINDOW) - kx;
    end
    return AW'(d);
  endfunction

  assign price     = PRICE_BITS'(s_axis_tdata);
  assign addr_fast = back_addr(wp_q, eff_fast);
  assign addr_slow = back_addr(wp_q, eff_slow);
  assign fill_d    = (fill_q < eff_slow) ? fill_q + LEN_W'(1) : fill_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      fill_q <= '0;
    end else begin
      if (acc) begin
        wp_q <= (32'(wp_q) == MAX_WINDOW - 1) ? '0 : wp_q + AW'(1);
      end
      if (restart) begin
        fill_q <= '0;
      end else if (acc) begin
        fill_q <= fill_d;
      end
    end
  end

  logic [PRICE_BITS-1:0] price1_q;
  logic                  sub_fast1_q, sub_slow1_q, full1_q;
  logic                  full2_q;
  logic [PRICE_BITS-1:0] drop_fast, drop_slow;

  always_ff @(posedge clk_i) begin
    if (acc) begin
      price1_q    <= price;
      sub_fast1_q <= fill_q >= eff_fast;
      sub_slow1_q <= fill_q >= eff_slow;
      full1_q     <= fill_d >= eff_slow;
    end
    if (ld2) begin
      full2_q <= full1_q;
    end
  end

  scd_ring #(
    .DEPTH (MAX_WINDOW),
    .WIDTH (PRICE_BITS)
  ) u_ring (
    .clk_i     (clk_i),
    .we_i      (acc),
    .waddr_i   (wp_q),
    .wdata_i   (price),
    .re_i      (acc),
    .raddr_a_i (addr_fast),
    .raddr_b_i (addr_slow),
    .rdata_a_o (drop_fast),
    .rdata_b_o (drop_slow)
  );

  // ---------------- sum stage ----------------
  scd_pkg::sum_ctl_t sum_ctl;
  logic [SUM_W-1:0]  fast_total, slow_total;

  assign sum_ctl.load     = ld2;
  assign sum_ctl.restart  = restart;
  assign sum_ctl.sub_fast = sub_fast1_q;
  assign sum_ctl.sub_slow = sub_slow1_q;

  scd_sums #(
    .PRICE_BITS (PRICE_BITS),
    .SUM_W      (SUM_W)
  ) u_sums (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (sum_ctl),
    .price_i      (price1_q),
    .drop_fast_i  (drop_fast),
    .drop_slow_i  (drop_slow),
    .fast_total_o (fast_total),
    .slow_total_o (slow_total)
  );

  // ---------------- multiply and compare stages ----------------
  scd_pkg::rel_ctl_t rel_ctl;
  scd_pkg::signal_e  signal;

  assign rel_ctl.mul_en  = ld3;
  assign rel_ctl.out_en  = ld4;
  assign rel_ctl.full    = full2_q;
  assign rel_ctl.restart = restart;

  scd_relate #(
    .SUM_W (SUM_W),
    .LEN_W (LEN_W)
  ) u_relate (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (rel_ctl),
    .fast_total_i (fast_total),
    .slow_total_i (slow_total),
    .fast_len_i   (eff_fast),
    .slow_len_i   (eff_slow),
    .signal_o     (signal)
  );

  assign m_axis_tdata = scd_pkg::OUT_TDATA_W'(signal);

endmodule

// ===== sv/scd_checker.sv =====
// Port-level checks for the crossover detector, bound to the top level.
// Depends on scd_pkg and sma_crossover_detector_defines.svh.
`timescale 1ns / 1ps
`include "sma_crossover_detector_defines.svh"

module scd_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [scd_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  // Stalled output beat stays put
  `SCD_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "output beat changed while stalled")

  // Only hold, buy or sell, padding bits zero
  `SCD_ASSERT_IMP(a_out_code, clk_i, rst_ni, m_axis_tvalid, (m_axis_tdata[scd_pkg::OUT_TDATA_W-1:scd_pkg::SIG_W] == '0) && (m_axis_tdata[scd_pkg::SIG_W-1:0] == scd_pkg::SIG_HOLD || m_axis_tdata[scd_pkg::SIG_W-1:0] == scd_pkg::SIG_BUY || m_axis_tdata[scd_pkg::SIG_W-1:0] == scd_pkg::SIG_SELL), "bad output beat")

  // A free output side never back-pressures the input
  `SCD_ASSERT_IMP(a_in_ready, clk_i, rst_ni, !m_axis_tvalid || m_axis_tready, s_axis_tready, "input stalled with output free")

  // A blocked input during an output stall implies a held output beat
  `SCD_ASSERT_NXT(a_no_accept_full, clk_i, rst_ni, s_axis_tvalid && !s_axis_tready && !m_axis_tready, m_axis_tvalid, "input blocked with empty output")

endmodule

bind sma_crossover_detector scd_checker u_scd_checker (.*);

// ===== bench/sma_crossover_detector_tb.sv =====
// Self-checking testbench for sma_crossover_detector: drives prices, predicts signals.
// Depends on scd_pkg and the sma_crossover_detector RTL only.
`timescale 1ns / 1ps

module sma_crossover_detector_tb;

  localparam int unsigned MAX_WIN     = 256;
  localparam int unsigned STALL_LIMIT = 5000;   // cycles with no beat on either side
  localparam int unsigned END_PAUSE   = 8;      // covers the pipeline depth plus margin

  // Indexes the block has no register for; writes there must be ignored
  localparam logic [scd_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [scd_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  typedef enum int unsigned {
    IDLE_NONE,
    IDLE_SRC,
    IDLE_SNK,
    IDLE_BOTH
  } idle_mode_e;

  logic                            clk_i         = 1'b0;
  logic                            rst_ni        = 1'b0;
  logic                            cfg_we_i      = 1'b0;
  logic [scd_pkg::CFG_IDX_W-1:0]   cfg_idx_i     = '0;
  logic [scd_pkg::CFG_W-1:0]       cfg_data_i    = '0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [scd_pkg::IN_TDATA_W-1:0]  s_axis_tdata  = '0;   // [31:0] price
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [scd_pkg::OUT_TDATA_W-1:0] m_axis_tdata;         // [1:0] signal, [7:2] zero

  sma_crossover_detector uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Crossover predictor: own copy of the lengths, price ring and running sums
  // ---------------------------------------------------------------------------
  logic [scd_pkg::CFG_W-1:0]      fast_len_q = scd_pkg::FAST_LEN_RST;
  logic [scd_pkg::CFG_W-1:0]      slow_len_q = scd_pkg::SLOW_LEN_RST;
  logic [scd_pkg::IN_TDATA_W-1:0] ring_prices [MAX_WIN];
  logic [7:0]                     ring_wr_ptr = '0;
  int unsigned                    run_fill    = 0;
  logic [39:0]                    fast_total  = '0;
  logic [39:0]                    slow_total  = '0;
  scd_pkg::rel_e                  last_rel    = scd_pkg::REL_EQUAL;

  scd_pkg::signal_e expected_signals [$];
  int unsigned mismatch_count = 0;
  int unsigned src_idle_pct   = 0;
  int unsigned snk_stall_pct  = 0;

  // Any write to a real register starts a new run; ring and pointer stay.
  task automatic restart_run();
    run_fill   = 0;
    fast_total = '0;
    slow_total = '0;
    last_rel   = scd_pkg::REL_EQUAL;
  endtask

  function automatic scd_pkg::signal_e predict_signal(
      input logic [scd_pkg::IN_TDATA_W-1:0] price);
    int unsigned      slow_n;
    int unsigned      fast_n;
    logic [7:0]       fast_slot;
    logic [7:0]       slow_slot;
    logic [63:0]      fast_cross;
    logic [63:0]      slow_cross;
    scd_pkg::rel_e    cur_rel;
    scd_pkg::signal_e sig;
    // zero length acts as one; slow clamps to the ring, fast to slow
    slow_n = (slow_len_q == '0) ? 1 : 32'(slow_len_q);
    if (slow_n > MAX_WIN) slow_n = MAX_WIN;
    fast_n = (fast_len_q == '0) ? 1 : 32'(fast_len_q);
    if (fast_n > slow_n) fast_n = slow_n;

    // drop the price leaving each window, then add the new one; 8-bit slots wrap
    fast_slot = ring_wr_ptr - 8'(fast_n);
    slow_slot = ring_wr_ptr - 8'(slow_n);
    if (run_fill >= fast_n) fast_total -= 40'(ring_prices[fast_slot]);
    if (run_fill >= slow_n) slow_total -= 40'(ring_prices[slow_slot]);
    fast_total += 40'(price);
    slow_total += 40'(price);
    ring_prices[ring_wr_ptr] = price;
    ring_wr_ptr++;
    if (run_fill < slow_n) run_fill++;

    sig = scd_pkg::SIG_HOLD;
    if (run_fill >= slow_n) begin
      // compare means without division: fast_total/fast_n vs slow_total/slow_n
      fast_cross = 64'(fast_total) * 64'(slow_n);
      slow_cross = 64'(slow_total) * 64'(fast_n);
      if (fast_cross < slow_cross) cur_rel = scd_pkg::REL_BELOW;
      else if (fast_cross > slow_cross) cur_rel = scd_pkg::REL_ABOVE;
      else cur_rel = scd_pkg::REL_EQUAL;
      // only a strict below<->above flip is a crossing; equal breaks it
      if (last_rel == scd_pkg::REL_BELOW && cur_rel == scd_pkg::REL_ABOVE) begin
        sig = scd_pkg::SIG_BUY;
      end else if (last_rel == scd_pkg::REL_ABOVE && cur_rel == scd_pkg::REL_BELOW) begin
        sig = scd_pkg::SIG_SELL;
      end
      last_rel = cur_rel;
    end
    return sig;
  endfunction

  // ---------------------------------------------------------------------------
  // Price source: trending walks (to get real crossings), flats, noise, extremes
  // ---------------------------------------------------------------------------
  logic [scd_pkg::IN_TDATA_W-1:0] walk_price = 32'h8000_0000;
  bit                             walk_up    = 1'b1;
  int unsigned                    walk_left  = 0;
  int unsigned                    walk_step  = 1;

  function automatic logic [scd_pkg::IN_TDATA_W-1:0] next_price();
    int unsigned pick;
    int unsigned jitter;
    if (walk_left == 0) begin
      walk_up   = ($urandom_range(0, 1) == 1);
      walk_left = $urandom_range(3, 40);
      walk_step = $urandom_range(1, 32'h00FF_FFFF) >> $urandom_range(0, 23);
    end
    walk_left--;
    pick = $urandom_range(0, 99);
    if (pick < 10) return $urandom;                        // noise
    if (pick < 15) return pick[0] ? '1 : '0;               // rails
    if (pick < 22) return walk_price;                      // flat, sets up touches
    jitter = $urandom_range(0, walk_step);
    if (walk_up)
      walk_price = (walk_price > 32'hFFFF_FFFF - jitter) ? '1 : walk_price + jitter;
    else
      walk_price = (walk_price < jitter) ? '0 : walk_price - jitter;
    return walk_price;
  endfunction

  // ---------------------------------------------------------------------------
  // Stream drivers
  // ---------------------------------------------------------------------------
  task automatic set_idle_mode(input idle_mode_e mode);
    case (mode)
      IDLE_NONE: begin
        src_idle_pct  = 0;
        snk_stall_pct = 0;
      end
      IDLE_SRC: begin
        src_idle_pct  = 49;
        snk_stall_pct = 0;
      end
      IDLE_SNK: begin
        src_idle_pct  = 0;
        snk_stall_pct = 49;
      end
      default: begin
        src_idle_pct  = 15;
        snk_stall_pct = 15;
      end
    endcase
  endtask

  // One input beat; the expected signal is queued at the accepting edge.
  task automatic send_price(input logic [scd_pkg::IN_TDATA_W-1:0] price);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= price;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    expected_signals.insert(expected_signals.size(), predict_signal(price));
  endtask

  // Every beat yields a signal, so an empty queue means the pipeline is empty.
  task automatic wait_results_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_signals.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [scd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [scd_pkg::CFG_W-1:0] data);
    wait_results_drained();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    if (idx == scd_pkg::REG_FAST_LEN) begin
      fast_len_q = data;
      restart_run();
    end else if (idx == scd_pkg::REG_SLOW_LEN) begin
      slow_len_q = data;
      restart_run();
    end
  endtask

  // Result checker, receiver stalls and watchdog share the clock edge.
  int unsigned quiet_cycles = 0;

  always @(posedge clk_i) begin
    logic [scd_pkg::OUT_TDATA_W-1:0] want;
    scd_pkg::signal_e                exp_sig;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_signals.size() == 0) begin
        $display("%0t: unexpected result beat, actual 0x%02h", $time, m_axis_tdata);
        mismatch_count++;
      end else begin
        exp_sig = expected_signals[0];
        expected_signals.delete(0);
        want = '0;
        want[scd_pkg::SIG_W-1:0] = exp_sig;
        if (m_axis_tdata !== want) begin
          $display("%0t: signal mismatch, expected 0x%02h (%s) actual 0x%02h",
                   $time, want, exp_sig.name(), m_axis_tdata);
          mismatch_count++;
        end
      end
    end
    m_axis_tready <= ($urandom_range(0, 99) >= snk_stall_pct);

    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
      $display("sma_crossover_detector test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset lengths 5/20, no register written yet.
  task automatic test_default_lengths();
    set_idle_mode(IDLE_BOTH);
    repeat (150) send_price(next_price());
  endtask

  // Fast 1 / slow 3: fill, buy, sell, spare-index writes keep the run going,
  // and a move through equal never counts as a crossing.
  task automatic test_crossings();
    logic [scd_pkg::IN_TDATA_W-1:0] seq [] = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                               32'h0, 32'hFFFF_FFFF, 32'h0};
    logic [scd_pkg::IN_TDATA_W-1:0] tail [] = '{32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0,
                                                32'h5, 32'h5, 32'h5, 32'h0};
    set_idle_mode(IDLE_NONE);
    write_reg(scd_pkg::REG_FAST_LEN, 9'd1);
    write_reg(scd_pkg::REG_SLOW_LEN, 9'd3);
    foreach (seq[i]) send_price(seq[i]);
    write_reg(REG_SPARE_A, 9'h1FF);
    write_reg(REG_SPARE_B, 9'h0AA);
    foreach (tail[i]) send_price(tail[i]);
  endtask

  // Zero lengths act as one; fast above slow clamps down to slow.
  task automatic test_length_corners();
    write_reg(scd_pkg::REG_FAST_LEN, 9'd0);
    write_reg(scd_pkg::REG_SLOW_LEN, 9'd0);
    send_price(32'h0);
    send_price(32'hFFFF_FFFF);
    send_price(32'h1234_5678);
    write_reg(scd_pkg::REG_FAST_LEN, 9'h1FF);
    write_reg(scd_pkg::REG_SLOW_LEN, 9'd2);
    send_price(32'hFFFF_FFFF);
    send_price(32'h0);
    send_price(32'hA5A5_A5A5);
    send_price(32'h5A5A_5A5A);
  endtask

  // Random phases over several window settings, cycling the idle patterns.
  task automatic test_random_windows();
    int unsigned fast_set [] = '{1, 3, 2, 8, 20, 40, 100, 256};
    int unsigned slow_set [] = '{2, 7, 9, 32, 12, 256, 511, 300};
    int unsigned beats    [] = '{120, 160, 120, 180, 120, 260, 250, 100};
    foreach (fast_set[i]) begin
      write_reg(scd_pkg::REG_FAST_LEN, scd_pkg::CFG_W'(fast_set[i]));
      write_reg(scd_pkg::REG_SLOW_LEN, scd_pkg::CFG_W'(slow_set[i]));
      set_idle_mode(idle_mode_e'(i % 4));
      repeat (beats[i]) send_price(next_price());
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_default_lengths();
    test_crossings();
    test_length_corners();
    test_random_windows();

    wait_results_drained();
    repeat (END_PAUSE) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("sma_crossover_detector test passed");
    end else begin
      $display("sma_crossover_detector test failed");
    end
    $finish;
  end

endmodule

// ===== sma_crossover_detector.f =====
+incdir+sv
sv/scd_pkg.sv
sv/scd_ring.sv
sv/scd_sums.sv
sv/scd_relate.sv
sv/sma_crossover_detector.sv
sv/scd_checker.sv
bench/sma_crossover_detector_tb.sv
